[hdl/i2cm_pkg.sv]
// Shared types and constants for the bit-level I2C master.
package i2cm_pkg;

	typedef enum logic [2:0] {
		OP_START = 3'd0,
		OP_STOP  = 3'd1,
		OP_WRITE = 3'd2,
		OP_READ  = 3'd3,
		OP_BIT   = 3'd4,
		OP_RESET = 3'd5
	} op_t;

	typedef enum logic [2:0] {
		REG_HALF   = 3'd0,
		REG_POLLS  = 3'd1,
		REG_PIVL   = 3'd2,
		REG_ROUNDS = 3'd3,
		REG_PAUSE  = 3'd4
	} reg_idx_t;

	localparam logic [1:0] FAULT_NONE    = 2'd0;
	localparam logic [1:0] FAULT_STRETCH = 2'd1;
	localparam logic [1:0] FAULT_STUCK   = 2'd2;

	localparam logic [3:0] RECOVERY_PULSES = 4'd10;
	localparam logic [3:0] BYTE_BITS       = 4'd8;

	typedef struct packed {
		logic [15:0] half_period_ticks;
		logic [7:0]  stretch_polls;
		logic [23:0] poll_interval_ticks;
		logic [7:0]  recovery_rounds;
		logic [23:0] round_pause_ticks;
	} cfg_t;

	// Tick as it travels from front to back.
	typedef struct packed {
		logic       take;
		op_t        op;
		logic [7:0] write_value;
		logic       bit_value;
		logic       scl_level;
		logic       sda_level;
	} tick_t;

	typedef struct packed {
		logic       scl_pull_low;
		logic       sda_pull_low;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_value;
		logic       ack_level;
		logic [1:0] fault;
	} res_t;

endpackage

[hdl/i2c_bit_level_master_top.sv]
// Top level of the bit-level I2C master: register file, input queue, sequencer.
// Each accepted transaction is one bus tick carrying sampled SCL/SDA and an optional
// command; it yields exactly one result transaction with the line drives and status.
// One transaction per clock is sustained unless results stall: a two-entry queue
// decouples the input from the sequencer, which updates its state once per tick,
// and the queue takes ticks during a result stall until both of its entries are full.
// Each tick is registered in the queue, and its result in the output register.
module i2c_bit_level_master_top import i2cm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        cmd_valid,
	input  logic [2:0]  op,
	input  logic [7:0]  write_value,
	input  logic        bit_value,
	input  logic        scl_level,
	input  logic        sda_level,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        scl_pull_low,
	output logic        sda_pull_low,
	output logic        busy_res,
	output logic        done_res,
	output logic [7:0]  read_value,
	output logic        ack_level,
	output logic [1:0]  fault
);
	cfg_t  cfg;
	logic  q_valid, q_pop;
	tick_t q_data;
	res_t  res;

	i2cm_cfg u_cfg (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
		.prdata, .pready, .cfg
	);

	i2cm_front u_front (
		.clk, .arst_n, .in_valid, .in_stall, .cmd_valid, .op, .write_value,
		.bit_value, .scl_level, .sda_level, .q_valid, .q_pop, .q_data
	);

	i2cm_back u_back (
		.clk, .arst_n, .cfg, .q_valid, .q_pop, .q_data, .out_valid,
		.out_stall, .res
	);

	assign scl_pull_low = res.scl_pull_low;
	assign sda_pull_low = res.sda_pull_low;
	assign busy_res     = res.busy_res;
	assign done_res     = res.done_res;
	assign read_value   = res.read_value;
	assign ack_level    = res.ack_level;
	assign fault        = res.fault;
endmodule

[hdl/i2cm_cfg.sv]
// APB register file holding the timing configuration.
module i2cm_cfg import i2cm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);
	cfg_t     cfg_q;
	reg_idx_t idx;

	assign idx    = reg_idx_t'(paddr[4:2]);
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.half_period_ticks   <= 16'd250;
			cfg_q.stretch_polls       <= 8'd50;
			cfg_q.poll_interval_ticks <= 24'd1000000;
			cfg_q.recovery_rounds     <= 8'd100;
			cfg_q.round_pause_ticks   <= 24'd100000;
		end else if (psel && penable && pwrite) begin
			case (idx)
				REG_HALF:   cfg_q.half_period_ticks   <= pwdata[15:0];
				REG_POLLS:  cfg_q.stretch_polls       <= pwdata[7:0];
				REG_PIVL:   cfg_q.poll_interval_ticks <= pwdata[23:0];
				REG_ROUNDS: cfg_q.recovery_rounds     <= pwdata[7:0];
				REG_PAUSE:  cfg_q.round_pause_ticks   <= pwdata[23:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_HALF:   prdata = {16'd0, cfg_q.half_period_ticks};
			REG_POLLS:  prdata = {24'd0, cfg_q.stretch_polls};
			REG_PIVL:   prdata = {8'd0, cfg_q.poll_interval_ticks};
			REG_ROUNDS: prdata = {24'd0, cfg_q.recovery_rounds};
			REG_PAUSE:  prdata = {8'd0, cfg_q.round_pause_ticks};
			default:    prdata = 32'd0;
		endcase
	end
endmodule

[hdl/i2cm_front.sv]
// Input stage: accepts ticks, classifies commands, feeds a two-entry queue.
module i2cm_front import i2cm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       cmd_valid,
	input  logic [2:0] op,
	input  logic [7:0] write_value,
	input  logic       bit_value,
	input  logic       scl_level,
	input  logic       sda_level,
	output logic       q_valid,
	input  logic       q_pop,
	output tick_t      q_data
);
	tick_t      mem_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	logic       push;
	tick_t      t;

	assign in_stall = (cnt_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_data   = mem_q[rd_q];

	always_comb begin
		t.take        = cmd_valid && (op <= 3'(OP_RESET));
		t.op          = op_t'(op);
		t.write_value = write_value;
		t.bit_value   = bit_value;
		t.scl_level   = scl_level;
		t.sda_level   = sda_level;
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= t;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (q_pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end
endmodule

[hdl/i2cm_back.sv]
// Bus sequencer: runs line actions, stretch polling and bus recovery.
module i2cm_back import i2cm_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	input  logic  q_valid,
	output logic  q_pop,
	input  tick_t q_data,
	output logic  out_valid,
	input  logic  out_stall,
	output res_t  res
);
	typedef enum logic [4:0] {
		PH_IDLE, ST_SDA, ST_PULLSDA, ST_PULLSCL, SP_SDA,
		RC_SDA, RC_LOW, RC_HIGH, RC_PAUSE, RC_PSCL, RC_PSDA, RC_STOPSDA,
		BT_DATA, BT_PSCL, BT_PSDA, RW_HALF1, RW_POLL, RW_HALF2
	} ph_t;

	ph_t         phase_q, resume_q;
	logic [23:0] tick_q;
	logic [7:0]  poll_q, round_q, shift_q, read_q;
	logic [3:0]  pulse_q, bit_q;
	logic        scl_q, sda_q, resume_start_q, ack_q;
	op_t         aop_q;
	logic [1:0]  fault_q;
	logic        ovalid_q;
	res_t        res_q;

	logic        adv;
	logic [15:0] h;
	logic [7:0]  sp, rr;
	logic [23:0] pi, rp;

	assign adv       = q_valid && (!ovalid_q || !out_stall);
	assign q_pop     = adv;
	assign out_valid = ovalid_q;
	assign res       = res_q;
	assign h  = (cfg.half_period_ticks == '0) ? 16'd1 : cfg.half_period_ticks;
	assign sp = (cfg.stretch_polls == '0) ? 8'd1 : cfg.stretch_polls;
	assign rr = (cfg.recovery_rounds == '0) ? 8'd1 : cfg.recovery_rounds;
	assign pi = (cfg.poll_interval_ticks == '0) ? 24'd1 : cfg.poll_interval_ticks;
	assign rp = (cfg.round_pause_ticks == '0) ? 24'd1 : cfg.round_pause_ticks;

	always_ff @(posedge clk or negedge arst_n) begin
		ph_t         ph, rph, np;
		logic [23:0] tk;
		logic [7:0]  pc, rc, sh, rd;
		logic [3:0]  pu, bc;
		logic        scl, sda, rs, ak, done, rdbit, fin, sl, dl;
		op_t         ao;
		logic [1:0]  fc;
		if (!arst_n) begin
			phase_q <= PH_IDLE; resume_q <= PH_IDLE; tick_q <= '0;
			poll_q <= '0; round_q <= '0; shift_q <= '0; read_q <= '0;
			pulse_q <= '0; bit_q <= '0; scl_q <= 1'b0; sda_q <= 1'b0;
			resume_start_q <= 1'b0; ack_q <= 1'b1; aop_q <= OP_START;
			fault_q <= FAULT_NONE; ovalid_q <= 1'b0; res_q <= '0;
		end else begin
			if (!out_stall) ovalid_q <= 1'b0;
			if (adv) begin
				ph = phase_q; rph = resume_q; tk = tick_q; pc = poll_q;
				rc = round_q; sh = shift_q; rd = read_q; pu = pulse_q;
				bc = bit_q; scl = scl_q; sda = sda_q; rs = resume_start_q;
				ak = ack_q; ao = aop_q; fc = fault_q; done = 1'b0;
				sl = q_data.scl_level; dl = q_data.sda_level;
				np = PH_IDLE; fin = 1'b0;
				if (ph == PH_IDLE) begin
					if (q_data.take) begin
						ao = q_data.op; fc = FAULT_NONE; bc = '0; rs = 1'b0;
						case (q_data.op)
							OP_START: np = ST_SDA;
							OP_STOP: begin rph = SP_SDA; np = RW_HALF1; end
							OP_WRITE: begin sh = q_data.write_value; np = BT_DATA; end
							OP_READ: begin sh = '0; np = BT_DATA; end
							OP_BIT: begin sh = {q_data.bit_value, 7'd0}; np = BT_DATA; end
							default: begin rs = 1'b0; rc = '0; np = RC_SDA; end
						endcase
					end
				end else begin
					tk = tk - 24'd1;
					if (tk == '0) begin
						rdbit = (ao == OP_READ) || (ao == OP_WRITE && bc >= BYTE_BITS);
						case (ph)
							ST_SDA: if (!dl) begin rs = 1'b1; rc = '0; np = RC_SDA; end
								else begin rph = ST_PULLSDA; np = RW_HALF1; end
							ST_PULLSDA: np = ST_PULLSCL;
							ST_PULLSCL: fin = 1'b1;
							SP_SDA: if (!dl) begin rs = 1'b0; rc = '0; np = RC_SDA; end
								else fin = 1'b1;
							RC_SDA: begin pu = '0; np = RC_LOW; end
							RC_LOW: np = RC_HIGH;
							RC_HIGH: begin
								pu = pu + 4'd1;
								if (pu < RECOVERY_PULSES) np = RC_LOW;
								else begin
									rc = rc + 8'd1;
									if (rc >= rr) begin
										fc = FAULT_STUCK;
										if (rs) begin rs = 1'b0; rph = ST_PULLSDA; np = RW_HALF1; end
										else fin = 1'b1;
									end else np = RC_PAUSE;
								end
							end
							RC_PAUSE: if (dl) np = RC_PSCL;
								else begin pu = '0; np = RC_LOW; end
							RC_PSCL: np = RC_PSDA;
							RC_PSDA: begin rph = RC_STOPSDA; np = RW_HALF1; end
							RC_STOPSDA: begin
								if (!dl) fc = FAULT_STUCK;
								if (rs) begin rs = 1'b0; rph = ST_PULLSDA; np = RW_HALF1; end
								else fin = 1'b1;
							end
							BT_DATA: begin rph = BT_PSCL; np = RW_HALF1; end
							BT_PSCL: np = BT_PSDA;
							BT_PSDA: begin
								if (ao == OP_BIT) fin = 1'b1;
								else if (ao == OP_WRITE && bc >= BYTE_BITS) fin = 1'b1;
								else begin
									if (ao == OP_WRITE) sh = {sh[6:0], 1'b0};
									bc = bc + 4'd1;
									if (ao == OP_READ && bc >= BYTE_BITS) begin
										rd = sh; fin = 1'b1;
									end else np = BT_DATA;
								end
							end
							RW_HALF1, RW_POLL, RW_HALF2: begin
								if (ph != RW_HALF2 && sl) np = RW_HALF2;
								else begin
									if (ph != RW_HALF2) pc = pc + 8'd1;
									if (ph != RW_HALF2 && pc < sp) np = RW_POLL;
									else begin
										if (ph != RW_HALF2) fc = FAULT_STRETCH;
										if (rph == BT_PSCL && rdbit) begin
											if (ao == OP_WRITE) ak = dl;
											else sh = {sh[6:0], dl};
										end
										np = rph;
									end
								end
							end
							default: fin = 1'b1;
						endcase
					end else np = ph;
				end
				if (fin) begin
					ph = PH_IDLE; tk = '0; done = 1'b1;
				end else if (np != ph || (phase_q != PH_IDLE && tk == '0)) begin
					ph = np; tk = {8'd0, h};
					rdbit = (ao == OP_READ) || (ao == OP_WRITE && bc >= BYTE_BITS);
					case (np)
						ST_SDA, SP_SDA, RC_SDA, RC_STOPSDA: sda = 1'b0;
						ST_PULLSDA, RC_PSDA, BT_PSDA: sda = 1'b1;
						ST_PULLSCL, RC_LOW, RC_PSCL, BT_PSCL: scl = 1'b1;
						RC_HIGH: scl = 1'b0;
						RC_PAUSE: tk = rp;
						BT_DATA: sda = rdbit ? 1'b0 : ~sh[7];
						RW_HALF1: begin scl = 1'b0; pc = '0; end
						RW_POLL: tk = pi;
						default: ;
					endcase
				end
				phase_q <= ph; resume_q <= rph; tick_q <= tk; poll_q <= pc;
				round_q <= rc; shift_q <= sh; read_q <= rd; pulse_q <= pu;
				bit_q <= bc; scl_q <= scl; sda_q <= sda; resume_start_q <= rs;
				ack_q <= ak; aop_q <= ao; fault_q <= fc;
				ovalid_q <= 1'b1;
				res_q.scl_pull_low <= scl;
				res_q.sda_pull_low <= sda;
				res_q.busy_res     <= (ph != PH_IDLE);
				res_q.done_res     <= done;
				res_q.read_value   <= rd;
				res_q.ack_level    <= ak;
				res_q.fault        <= fc;
			end
		end
	end
endmodule
